// ===== design/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// lr_pkg
// shared widths, defaults and controller/datapath interface types
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int SIDE_DEF  = 64;  // raster side in pixels
  localparam int COORD_W   = 6;   // coordinate field width
  localparam int COLOR_W   = 8;   // color component width
  localparam int REG_W     = 7;   // configuration register width
  localparam int CFG_IDX_W = 1;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 40;

  localparam logic [REG_W-1:0] RASTER_RST = REG_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a line request
    logic setup;  // compute spans and directions
    logic step;   // advance one pixel
  } lr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;   // current pixel is the end point
  } lr_stat_t;

endpackage

// ===== design/lr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lr_ctrl
// sequencer: capture request, a setup state, then walk pixel by pixel
// ----------------------------------------------------------------------------
module lr_ctrl import lr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  input  lr_stat_t stat_i,
  output lr_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_tready_o  = 1'b0;
    m_tvalid_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          cmd_o.step = 1'b1;
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/lr_datapath.sv =====
// ----------------------------------------------------------------------------
// lr_datapath
// endpoint registers, span setup, error accumulator and clip compare
// ----------------------------------------------------------------------------
module lr_datapath import lr_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lr_cmd_t              cmd_i,
  output lr_stat_t             stat_o,
  input  logic [COORD_W-1:0]   start_x_i,
  input  logic [COORD_W-1:0]   start_y_i,
  input  logic [COORD_W-1:0]   end_x_i,
  input  logic [COORD_W-1:0]   end_y_i,
  input  logic [COLOR_W-1:0]   red_i,
  input  logic [COLOR_W-1:0]   green_i,
  input  logic [COLOR_W-1:0]   blue_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  output logic [COORD_W-1:0]   pixel_x_o,
  output logic [COORD_W-1:0]   pixel_y_o,
  output logic [COLOR_W-1:0]   red_o,
  output logic [COLOR_W-1:0]   green_o,
  output logic [COLOR_W-1:0]   blue_o,
  output logic                 inside_o
);

  localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam logic [CW-1:0] MAX_C = CW'(SIDE - 1);

  function automatic logic [CW-1:0] clamp(input logic [COORD_W-1:0] v);
    logic [CW-1:0] r;
    if (int'(v) >= SIDE) begin
      r = MAX_C;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  logic [REG_W-1:0]   width_q, height_q;
  logic [CW-1:0]      x_q, y_q, xe_q, ye_q;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;
  logic [CW-1:0]      major_q, minor_q, cnt_q;
  logic [CW:0]        err_q;
  logic               x_nz_q, x_neg_q, y_nz_q, y_neg_q, major_x_q;

  // setup arithmetic
  logic [CW:0]   dx, dy;
  logic [CW-1:0] aw, ah;
  logic          maj_x;

  assign dx    = {1'b0, xe_q} - {1'b0, x_q};
  assign dy    = {1'b0, ye_q} - {1'b0, y_q};
  assign aw    = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ah    = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign maj_x = aw > ah;

  // step arithmetic
  logic [CW:0]   err_sum;
  logic          diag, mv_x, mv_y;
  logic [CW-1:0] x_nxt, y_nxt;

  assign err_sum = err_q + {1'b0, minor_q};
  assign diag    = err_sum >= {1'b0, major_q};
  assign mv_x    = x_nz_q && (diag || major_x_q);
  assign mv_y    = y_nz_q && (diag || !major_x_q);
  assign x_nxt   = x_neg_q ? x_q - CW'(1) : x_q + CW'(1);
  assign y_nxt   = y_neg_q ? y_q - CW'(1) : y_q + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RASTER_RST;
      height_q <= RASTER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= clamp(start_x_i);
      y_q     <= clamp(start_y_i);
      xe_q    <= clamp(end_x_i);
      ye_q    <= clamp(end_y_i);
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end else if (cmd_i.setup) begin
      x_nz_q    <= xe_q != x_q;
      x_neg_q   <= dx[CW];
      y_nz_q    <= ye_q != y_q;
      y_neg_q   <= dy[CW];
      major_x_q <= maj_x;
      major_q   <= maj_x ? aw : ah;
      minor_q   <= maj_x ? ah : aw;
      cnt_q     <= maj_x ? aw : ah;
      err_q     <= {1'b0, (maj_x ? aw : ah) >> 1};
    end else if (cmd_i.step) begin
      err_q <= diag ? err_sum - {1'b0, major_q} : err_sum;
      cnt_q <= cnt_q - CW'(1);
      if (mv_x) begin
        x_q <= x_nxt;
      end
      if (mv_y) begin
        y_q <= y_nxt;
      end
    end
  end

  assign stat_o.last = cnt_q == '0;
  assign pixel_x_o   = COORD_W'(x_q);
  assign pixel_y_o   = COORD_W'(y_q);
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign inside_o    = (REG_W'(x_q) < width_q) && (REG_W'(y_q) < height_q);

endmodule

// ===== design/line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// line_rasterizer_top
// all-octant bresenham line walker, one pixel write per step
// ----------------------------------------------------------------------------
// after a line request is taken the setup state follows; the first pixel is
//   offered in the walk state after it and goes out when the sink is ready
// each line passes the request, setup and walk states; the walk gives one pixel
//   per cycle while the sink is ready, major span + 1 pixels per line
// a new request is taken only once the last pixel of the line has gone out
// reset: asynchronous active low, raster width and height return to 64
module line_rasterizer_top import lr_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // start_x, start_y, end_x, end_y, line_red, line_green, line_blue
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, zero fill
  output logic [M_DATA_W-1:0]  m_axis_tdata,
  // inside_clip
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  lr_cmd_t  cmd;
  lr_stat_t stat;

  logic [COORD_W-1:0] pixel_x, pixel_y;
  logic [COLOR_W-1:0] red, green, blue;

  lr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lr_datapath #(
    .SIDE (SIDE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .start_x_i  (s_axis_tdata[5:0]),
    .start_y_i  (s_axis_tdata[11:6]),
    .end_x_i    (s_axis_tdata[17:12]),
    .end_y_i    (s_axis_tdata[23:18]),
    .red_i      (s_axis_tdata[31:24]),
    .green_i    (s_axis_tdata[39:32]),
    .blue_i     (s_axis_tdata[47:40]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pixel_x_o  (pixel_x),
    .pixel_y_o  (pixel_y),
    .red_o      (red),
    .green_o    (green),
    .blue_o     (blue),
    .inside_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, blue, green, red, pixel_y, pixel_x};
  assign m_axis_tlast = stat.last;

endmodule

// ===== dv/line_rasterizer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_top_test
// self-checking bench for the bresenham line walker: a directed table of
// line requests (points, axis-aligned and diagonal runs, all eight octants,
// clip register extremes) followed by randomized phases under new raster
// sizes; each pixel is checked against the table row or a local walk of its line
// ----------------------------------------------------------------------------
module line_rasterizer_top_test;
  import lr_pkg::*;

  localparam int PREDICT     = -1;   // clip column value: use the walk
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 19;
  localparam int SETTLE      = 8;
  localparam int HOLD_AT     = 300;  // pixel count at which the sink stalls
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // request layout, lowest bits first: start_x, start_y, end_x, end_y, r, g, b
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] start_x;
  } line_t;

  // tuser, tlast, then tdata low bits: x, y, r, g, b
  typedef struct packed {
    logic               in_clip;
    logic               is_last;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pixel_t;

  typedef struct {
    int w, h, sx, sy, ex, ey, r, g, b, clip;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  // w, h, start, end, color, expected clip of a single-point line
  dir_row_t dir_table [DIR_ROWS] = '{
    '{64, 64,  0,  0,  0,  0, 8'h00, 8'h00, 8'h00, 1},
    '{64, 64, 63, 63, 63, 63, 8'hff, 8'hff, 8'hff, 1},
    '{64, 64,  0, 10, 63, 10, 8'h12, 8'h34, 8'h56, PREDICT},
    '{64, 64, 63, 20,  0, 20, 8'ha5, 8'h5a, 8'hc3, PREDICT},
    '{64, 64,  5,  0,  5, 63, 8'h01, 8'h80, 8'hfe, PREDICT},
    '{64, 64, 58, 63, 58,  0, 8'h7f, 8'h00, 8'h33, PREDICT},
    '{64, 64,  0,  0, 63, 63, 8'hcc, 8'h11, 8'h99, PREDICT},
    '{64, 64, 63,  0,  0, 63, 8'h55, 8'haa, 8'h0f, PREDICT},
    '{64, 64, 32, 32, 40, 35, 8'h10, 8'h20, 8'h30, PREDICT},
    '{64, 64, 32, 32, 35, 40, 8'h11, 8'h21, 8'h31, PREDICT},
    '{64, 64, 32, 32, 29, 40, 8'h12, 8'h22, 8'h32, PREDICT},
    '{64, 64, 32, 32, 24, 35, 8'h13, 8'h23, 8'h33, PREDICT},
    '{64, 64, 32, 32, 24, 29, 8'h14, 8'h24, 8'h34, PREDICT},
    '{64, 64, 32, 32, 29, 24, 8'h15, 8'h25, 8'h35, PREDICT},
    '{64, 64, 32, 32, 35, 24, 8'h16, 8'h26, 8'h36, PREDICT},
    '{64, 64, 32, 32, 40, 29, 8'h17, 8'h27, 8'h37, PREDICT},
    '{64, 64,  0,  0,  1,  0, 8'hf0, 8'h0f, 8'h3c, PREDICT},
    '{ 0,  0, 10, 10, 10, 10, 8'h44, 8'h88, 8'h22, 0},
    '{ 0,  0,  0,  0, 63,  5, 8'h66, 8'h77, 8'h88, PREDICT},
    '{127, 127, 63, 63, 63, 63, 8'h9a, 8'hbc, 8'hde, 1},
    '{127, 127, 63,  0,  0, 40, 8'h21, 8'h43, 8'h65, PREDICT},
    '{32, 16,  0,  0, 63, 63, 8'hab, 8'hcd, 8'hef, PREDICT},
    '{ 1,  1,  0,  0,  0,  0, 8'h5c, 8'hc5, 8'h3a, 1},
    '{ 1,  1,  1,  1,  1,  1, 8'ha3, 8'h3a, 8'hc5, 0}
  };

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_WIDTH;
  logic [REG_W-1:0]     cfg_data_i    = '0;

  pixel_t pixel_q [$];
  int     raster_w = 64;
  int     raster_h = 64;
  bit     quiet;
  int     lines_sent;
  int     pixels_seen;
  int     raster_writes;
  int     mismatches;

  line_rasterizer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d pixels still expected", pixel_q.size());
    $display("line_rasterizer_top_test NOT OK");
    $finish;
  end

  // bresenham walk of one line, pushing every pixel it should produce
  function automatic void walk_line(line_t ln);
    int x, y, dx, dy, stx, sty, adx, ady, span, minor, mjx, mjy, acc;
    pixel_t px;
    x   = ln.start_x;
    y   = ln.start_y;
    dx  = int'(ln.end_x) - x;
    dy  = int'(ln.end_y) - y;
    stx = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
    sty = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    // ties go to the y axis
    if (adx > ady) begin
      span = adx; minor = ady; mjx = stx; mjy = 0;
    end else begin
      span = ady; minor = adx; mjx = 0; mjy = sty;
    end
    acc = span >>> 1;
    for (int i = 0; i <= span; i++) begin
      px.x       = COORD_W'(x);
      px.y       = COORD_W'(y);
      px.red     = ln.red;
      px.green   = ln.green;
      px.blue    = ln.blue;
      px.in_clip = (x < raster_w) && (y < raster_h);
      px.is_last = (i == span);
      pixel_q.push_back(px);
      acc += minor;
      if (acc >= span) begin
        acc -= span;
        x += stx;
        y += sty;
      end else begin
        x += mjx;
        y += mjy;
      end
    end
  endfunction

  // clip extent drawn with the extremes well represented
  function automatic int pick_extent();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return 64;
      3: return 127;
      default: return $urandom_range(2, 63);
    endcase
  endfunction

  // one line request; a clip value of zero or one types in the single pixel
  task automatic send_line(line_t ln, int clip);
    int gap;
    pixel_t px;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= ln;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    lines_sent++;
    if (clip == PREDICT) begin
      walk_line(ln);
    end else begin
      px = '{in_clip: clip[0], is_last: 1'b1, blue: ln.blue, green: ln.green,
             red: ln.red, y: ln.start_y, x: ln.start_x};
      pixel_q.push_back(px);
    end
  endtask

  // stop offering requests and let every pending pixel drain
  task automatic idle_out();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_raster(int w, int h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WIDTH;
    cfg_data_i <= REG_W'(w);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= REG_W'(h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    raster_w = w;
    raster_h = h;
    raster_writes++;
  endtask

  initial begin : pixel_sink
    int gap;
    bit held;
    pixel_t got, want;
    held = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 19);
      // long stall so the walker backs up and blocks new requests
      if (!held && pixels_seen >= HOLD_AT) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = {m_axis_tuser, m_axis_tlast, m_axis_tdata[35:0]};
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pixel x=%0d y=%0d", got.x, got.y);
      end else begin
        want = pixel_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue ||
            got.in_clip !== want.in_clip || got.is_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"pixel %0d: exp x=%0d y=%0d rgb=%h%h%h clip=%b last=%b,",
                      " got x=%0d y=%0d rgb=%h%h%h clip=%b last=%b"},
                     pixels_seen, want.x, want.y, want.red, want.green, want.blue,
                     want.in_clip, want.is_last, got.x, got.y, got.red, got.green,
                     got.blue, got.in_clip, got.is_last);
        end
      end
    end
  end

  initial begin : stimulus
    line_t ln;
    int x0, y0, x1, y1;
    quiet = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].w != raster_w || dir_table[i].h != raster_h) begin
        idle_out();
        set_raster(dir_table[i].w, dir_table[i].h);
      end
      ln = '{blue: dir_table[i].b[7:0], green: dir_table[i].g[7:0],
             red: dir_table[i].r[7:0], end_y: dir_table[i].ey[5:0],
             end_x: dir_table[i].ex[5:0], start_y: dir_table[i].sy[5:0],
             start_x: dir_table[i].sx[5:0]};
      send_line(ln, dir_table[i].clip);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_out();
      set_raster(pick_extent(), pick_extent());
      quiet = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        x0 = $urandom_range(0, SIDE_DEF - 1);
        y0 = $urandom_range(0, SIDE_DEF - 1);
        if ($urandom_range(0, 3) == 0) begin
          // short line near the start point
          x1 = x0 + $urandom_range(0, 6) - 3;
          y1 = y0 + $urandom_range(0, 6) - 3;
          x1 = (x1 < 0) ? 0 : (x1 > SIDE_DEF - 1) ? SIDE_DEF - 1 : x1;
          y1 = (y1 < 0) ? 0 : (y1 > SIDE_DEF - 1) ? SIDE_DEF - 1 : y1;
        end else begin
          x1 = $urandom_range(0, SIDE_DEF - 1);
          y1 = $urandom_range(0, SIDE_DEF - 1);
        end
        ln = '{blue: 8'($urandom), green: 8'($urandom), red: 8'($urandom),
               end_y: 6'(y1), end_x: 6'(x1), start_y: 6'(y0), start_x: 6'(x0)};
        send_line(ln, PREDICT);
      end
    end
    quiet = 1'b0;
    idle_out();

    $display("%0d line requests walked into %0d pixels", lines_sent, pixels_seen);
    $display("%0d raster size settings, %0d mismatches", raster_writes, mismatches);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("line_rasterizer_top_test OK");
    end else begin
      $display("line_rasterizer_top_test NOT OK");
    end
    $finish;
  end

endmodule
